// ===== src/struct_array_packer_defines.svh =====
// Assertion macros for the struct array packer.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef STRUCT_ARRAY_PACKER_DEFINES_SVH
`define STRUCT_ARRAY_PACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SAP_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SAP_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sap_pkg.sv =====
// Shared types, constants and helper functions for the struct array packer.
// No dependencies.
package sap_pkg;

  localparam int MAX_FIELDS      = 32;
  localparam int MAX_FIELD_BYTES = 8;
  localparam int MAX_RESULTS     = 10;
  localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  localparam logic [1:0] REG_STRUCT_COUNT  = 2'd0;
  localparam logic [1:0] REG_FIELD_COUNT   = 2'd1;
  localparam logic [1:0] REG_FIELD_TYPES   = 2'd2;
  localparam logic [1:0] REG_LITTLE_ENDIAN = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } sap_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       all_done;
  } sap_out_t;

  function automatic logic [1:0] type_of(logic [63:0] types, logic [4:0] idx);
    return types[{idx, 1'b0} +: 2];
  endfunction

  function automatic logic [3:0] size_of(logic [1:0] t);
    logic [3:0] s;
    s = 4'd1 << t;
    if (s > 4'(MAX_FIELD_BYTES)) s = 4'(MAX_FIELD_BYTES);
    return s;
  endfunction

endpackage

// ===== src/struct_array_packer.sv =====
// Struct array packer: strips alignment padding, optionally byte-swaps fields,
// and emits a header on start. Depends on sap_pkg and the assertion macro header.
//
//   channel | signals                          | word
//   in      | in_valid, in_stall, in_word      | sap_in_t: req_type, data_byte
//   out     | out_valid, out_stall, out_word   | sap_out_t: out_byte, out_last, all_done
//   cfg     | psel, penable, pwrite, paddr ... | 64-bit registers at 8*i
//
// An input word's results land in a result register.
// A word with k results (k from 0 to 10) holds that register until all k have left;
// a word with one or zero results lets the next word in every cycle while out_stall is low.
// The next input word is taken in the cycle the final result leaves.
// rst is synchronous: counters and configuration clear and the result register empties (its bytes are not reset).
// out_stall holds the result register and, through it, the input side.
`include "struct_array_packer_defines.svh"

module struct_array_packer (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sap_pkg::sap_in_t in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output sap_pkg::sap_out_t out_word,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import sap_pkg::*;

  logic [7:0]  struct_count;
  logic [5:0]  field_count;
  logic [63:0] field_types;
  logic        little_endian;

  logic [7:0]  struct_index, struct_index_next;
  logic [4:0]  field_index, field_index_next;
  logic        tail_padding_phase, tail_padding_phase_next;
  logic [2:0]  offset_in_struct, offset_in_struct_next;
  logic [2:0]  byte_in_field, byte_in_field_next;
  logic [7:0]  swap_buffer [MAX_FIELD_BYTES];
  logic        swap_we;
  logic [2:0]  swap_idx;

  logic [7:0]     rbuf [MAX_RESULTS];
  logic [7:0]     rbuf_next [MAX_RESULTS];
  logic [CNT_W-1:0] rcnt, rcnt_next;
  logic           rdone, rdone_next;

  logic       accept, take, cfg_we;
  logic [1:0] reg_sel;
  logic [5:0] n_eff;
  logic [3:0] present;
  logic [3:0] max_size;
  logic [2:0] max_mask;
  logic [7:0] swap_cur [MAX_FIELD_BYTES];

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:3];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      struct_count  <= '0;
      field_count   <= 6'd1;
      field_types   <= '0;
      little_endian <= 1'b0;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_STRUCT_COUNT:  struct_count  <= pwdata[7:0];
        REG_FIELD_COUNT:   field_count   <= pwdata[5:0];
        REG_FIELD_TYPES:   field_types   <= pwdata;
        REG_LITTLE_ENDIAN: little_endian <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_STRUCT_COUNT:  prdata = {56'd0, struct_count};
      REG_FIELD_COUNT:   prdata = {58'd0, field_count};
      REG_FIELD_TYPES:   prdata = field_types;
      REG_LITTLE_ENDIAN: prdata = {63'd0, little_endian};
      default:           prdata = '0;
    endcase
  end

  // Effective field count and largest field size.
  always_comb begin
    n_eff = (field_count > 6'(MAX_FIELDS)) ? 6'(MAX_FIELDS) : field_count;
    if (n_eff > 6'd32) n_eff = 6'd32;
    present = '0;
    for (int f = 0; f < 32; f++) begin
      if (6'(f) < n_eff) present[type_of(field_types, 5'(f))] = 1'b1;
    end
    if (present[3])      max_size = size_of(2'd3);
    else if (present[2]) max_size = size_of(2'd2);
    else if (present[1]) max_size = size_of(2'd1);
    else                 max_size = 4'd1;
    max_mask = 3'(max_size - 4'd1);
  end

  assign in_stall  = (rcnt != '0) && !((rcnt == CNT_W'(1)) && !out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (rcnt != '0);
  assign take      = out_valid && !out_stall;

  always_comb begin
    logic       stop, last;
    logic [3:0] sz;
    logic [2:0] smask;
    logic [3:0] groups;
    struct_index_next       = struct_index;
    field_index_next        = field_index;
    tail_padding_phase_next = tail_padding_phase;
    offset_in_struct_next   = offset_in_struct;
    byte_in_field_next      = byte_in_field;
    swap_we                 = 1'b0;
    swap_idx                = byte_in_field;
    rcnt_next               = '0;
    stop                    = 1'b0;
    last                    = 1'b0;
    sz                      = 4'd1;
    smask                   = '0;
    groups                  = 4'(({1'b0, n_eff} + 7'd3) >> 2);
    for (int i = 0; i < MAX_RESULTS; i++) rbuf_next[i] = '0;
    for (int j = 0; j < MAX_FIELD_BYTES; j++) swap_cur[j] = swap_buffer[j];

    if (accept) begin
      if (in_word.req_type == REQ_START) begin
        struct_index_next       = '0;
        field_index_next        = '0;
        tail_padding_phase_next = 1'b0;
        offset_in_struct_next   = '0;
        byte_in_field_next      = '0;
        rbuf_next[0] = struct_count;
        rbuf_next[1] = {little_endian, 1'b0, n_eff};
        for (int g = 0; g < 8; g++) begin
          for (int j = 0; j < 4; j++) begin
            if (6'(4 * g + j) < n_eff)
              rbuf_next[2 + g][7 - 2 * j -: 2] = type_of(field_types, 5'(4 * g + j));
          end
        end
        rcnt_next = CNT_W'(groups + 4'd2);
      end else if (!(n_eff == '0 || struct_index >= struct_count)) begin
        if (!tail_padding_phase_next && ({1'b0, field_index_next} >= n_eff)) begin
          tail_padding_phase_next = 1'b1;
          if ((offset_in_struct_next & max_mask) == '0) begin
            struct_index_next       = struct_index_next + 8'd1;
            field_index_next        = '0;
            tail_padding_phase_next = 1'b0;
            offset_in_struct_next   = '0;
            byte_in_field_next      = '0;
          end
          if (struct_index_next >= struct_count) stop = 1'b1;
        end
        if (!stop) begin
          if (tail_padding_phase_next) begin
            offset_in_struct_next = offset_in_struct_next + 3'd1;
            if ((offset_in_struct_next & max_mask) == '0) begin
              struct_index_next       = struct_index_next + 8'd1;
              field_index_next        = '0;
              tail_padding_phase_next = 1'b0;
              offset_in_struct_next   = '0;
              byte_in_field_next      = '0;
            end
          end else begin
            sz    = size_of(type_of(field_types, field_index_next));
            smask = 3'(sz - 4'd1);
            if (byte_in_field_next == '0 && (offset_in_struct_next & smask) != '0) begin
              offset_in_struct_next = offset_in_struct_next + 3'd1;
            end else begin
              last = ({1'b0, byte_in_field_next} + 4'd1) >= sz;
              if (little_endian) begin
                rbuf_next[0] = in_word.data_byte;
                rcnt_next    = CNT_W'(1);
              end else begin
                swap_we  = 1'b1;
                swap_idx = byte_in_field_next;
                swap_cur[byte_in_field_next] = in_word.data_byte;
                if (last) begin
                  for (int k = 0; k < MAX_FIELD_BYTES; k++) begin
                    case (sz)
                      4'd8: rbuf_next[k] = swap_cur[7 - k];
                      4'd4: if (k < 4) rbuf_next[k] = swap_cur[3 - k];
                      4'd2: if (k < 2) rbuf_next[k] = swap_cur[1 - k];
                      default: if (k < 1) rbuf_next[k] = swap_cur[0];
                    endcase
                  end
                  rcnt_next = CNT_W'(sz);
                end
              end
              offset_in_struct_next = offset_in_struct_next + 3'd1;
              if (last) begin
                byte_in_field_next = '0;
                if (({1'b0, field_index_next} + 6'd1) >= n_eff) begin
                  tail_padding_phase_next = 1'b1;
                  if ((offset_in_struct_next & max_mask) == '0) begin
                    struct_index_next       = struct_index_next + 8'd1;
                    field_index_next        = '0;
                    tail_padding_phase_next = 1'b0;
                    offset_in_struct_next   = '0;
                  end
                end else begin
                  field_index_next = field_index_next + 5'd1;
                end
              end else begin
                byte_in_field_next = byte_in_field_next + 3'd1;
              end
            end
          end
        end
      end
    end
    rdone_next = (n_eff == '0) || (struct_index_next >= struct_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      struct_index       <= '0;
      field_index        <= '0;
      tail_padding_phase <= 1'b0;
      offset_in_struct   <= '0;
      byte_in_field      <= '0;
      rcnt               <= '0;
      rdone              <= 1'b0;
    end else begin
      struct_index       <= struct_index_next;
      field_index        <= field_index_next;
      tail_padding_phase <= tail_padding_phase_next;
      offset_in_struct   <= offset_in_struct_next;
      byte_in_field      <= byte_in_field_next;
      if (accept && rcnt_next != '0) begin
        rcnt  <= rcnt_next;
        rdone <= rdone_next;
      end else if (take) begin
        rcnt <= rcnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (swap_we) swap_buffer[swap_idx] <= in_word.data_byte;
    if (accept && rcnt_next != '0) begin
      for (int i = 0; i < MAX_RESULTS; i++) rbuf[i] <= rbuf_next[i];
    end else if (take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) rbuf[i] <= rbuf[i + 1];
      rbuf[MAX_RESULTS - 1] <= '0;
    end
  end

  assign out_word.out_byte = rbuf[0];
  assign out_word.out_last = (rcnt == CNT_W'(1));
  assign out_word.all_done = rdone;

  `SAP_ASSERT_IMP(a_no_overwrite, clk, rst, out_valid && out_stall, in_stall, "result overwritten while stalled")
  `SAP_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, rcnt <= CNT_W'(MAX_RESULTS), "result count out of range")
  `SAP_ASSERT_NXT(a_start_emits, clk, rst, accept && in_word.req_type == REQ_START, out_valid && rcnt >= CNT_W'(2), "start word without header")
  `SAP_ASSERT_NXT(a_drain_continues, clk, rst, take && !out_word.out_last, out_valid, "result words lost before final")

endmodule
